[rtl/kpsd_pkg.sv]
// Shared types and constants for the keypad scan, debounce and auto-repeat block.
// No dependencies; used by keypad_scan_debounce_repeat.
`default_nettype none

package kpsd_pkg;

  // Default matrix size
  localparam int NumRowsDef = 4;
  localparam int NumColsDef = 4;

  // Field and register widths
  localparam int RowW  = 4;
  localparam int ColW  = 2;
  localparam int MapW  = 16;
  localparam int CntW  = 10;
  localparam int HeldW = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // Saturation limits
  localparam logic [CntW-1:0]  CntMax  = '1;
  localparam logic [HeldW-1:0] HeldMax = '1;

  // Register reset values
  localparam logic [CntW-1:0]  RoundsReset    = 10'd400;
  localparam logic [CntW-1:0]  ThresholdReset = 10'd300;
  localparam logic [HeldW-1:0] RepeatReset    = 4'd10;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROUNDS    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_REPEAT    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  // One result transaction
  typedef struct packed {
    logic [ColW-1:0] col_drive;
    logic            window_done;
    logic [MapW-1:0] key_state;
    logic [MapW-1:0] key_events;
  } res_t;

endpackage

`default_nettype wire

[rtl/keypad_scan_debounce_repeat.sv]
// Keypad matrix scanner: per-key sample counting, windowed debounce and auto-repeat.
// Depends on kpsd_pkg for widths, reset values, register indexes and the result type.
// A result is registered into the head, or into the skid entry when the head is stalled.
// Throughput: one input transaction per cycle while in_stall is low; all per-key counters
// of the driven column and the window close logic update in that single cycle. A two-entry
// output buffer keeps accepting while one result waits. Reset clears counters, the pressed
// map, the buffer and loads the register defaults; no clearing pass is needed.
`default_nettype none

module keypad_scan_debounce_repeat #(
  parameter int NUM_ROWS = kpsd_pkg::NumRowsDef,
  parameter int NUM_COLS = kpsd_pkg::NumColsDef
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // input channel
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [kpsd_pkg::RowW-1:0]     in_row_bits,
  // result channel
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [kpsd_pkg::ColW-1:0]     out_col_drive,
  output logic                          out_window_done,
  output logic [kpsd_pkg::MapW-1:0]     out_key_state,
  output logic [kpsd_pkg::MapW-1:0]     out_key_events,
  // configuration channel
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [kpsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  [kpsd_pkg::CfgDataW-1:0] cfg_data
);

  localparam int NumKeys = NUM_ROWS * NUM_COLS;
  localparam int CW      = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam int RW      = kpsd_pkg::RowW;
  localparam int MW      = kpsd_pkg::MapW;
  localparam int CntW    = kpsd_pkg::CntW;
  localparam int HeldW   = kpsd_pkg::HeldW;
  localparam logic [CW-1:0] LastCol = CW'(NUM_COLS - 1);

  // configuration registers
  logic [CntW-1:0]  rounds_r;
  logic [CntW-1:0]  threshold_r;
  logic [HeldW-1:0] repeat_r;

  // scan state
  logic [CW-1:0]      col_r, col_nxt;
  logic [CntW-1:0]    round_r, round_nxt;
  logic [CntW-1:0]    cnt_r   [NumKeys];
  logic [CntW-1:0]    cnt_nxt [NumKeys];
  logic [HeldW-1:0]   held_r   [NumKeys];
  logic [HeldW-1:0]   held_nxt [NumKeys];
  logic [NumKeys-1:0] prev_r, prev_nxt;

  // combinational work
  logic [NUM_ROWS+RW-1:0] row_ext;
  logic [CntW-1:0]        cnt_inc [NumKeys];
  logic [CntW-1:0]        round_inc;
  logic                   col_wrap;
  logic                   close;
  logic [NumKeys-1:0]     pressed;
  logic [NumKeys-1:0]     events;
  logic [NumKeys+MW-1:0]  pressed_ext, events_ext;
  logic [CW+kpsd_pkg::ColW-1:0] col_ext;
  kpsd_pkg::res_t         res;

  // output buffer
  kpsd_pkg::res_t head_r, skid_r;
  logic           head_vld_r, skid_vld_r;
  logic           push, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign push      = in_valid && !in_stall;
  assign pop       = head_vld_r && !out_stall;

  // Write configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r    <= kpsd_pkg::RoundsReset;
      threshold_r <= kpsd_pkg::ThresholdReset;
      repeat_r    <= kpsd_pkg::RepeatReset;
    end else if (cfg_valid && cfg_ready) begin
      case (kpsd_pkg::cfg_idx_t'(cfg_index))
        kpsd_pkg::CFG_ROUNDS:    rounds_r    <= cfg_data;
        kpsd_pkg::CFG_THRESHOLD: threshold_r <= cfg_data;
        kpsd_pkg::CFG_REPEAT:    repeat_r    <= cfg_data[HeldW-1:0];
        default: ;
      endcase
    end
  end

  // Count samples, advance column and round, close window
  always_comb begin
    row_ext   = {{NUM_ROWS{1'b0}}, in_row_bits};
    col_wrap  = (col_r == LastCol);
    col_nxt   = col_wrap ? '0 : col_r + CW'(1);
    round_inc = round_r + CntW'(1);
    close     = col_wrap && ((round_inc >= rounds_r) || (round_inc == '0));
    round_nxt = col_wrap ? (close ? '0 : round_inc) : round_r;

    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if (row_ext[r] && (col_r == CW'(c)) && (cnt_r[r*NUM_COLS+c] != kpsd_pkg::CntMax)) begin
          cnt_inc[r*NUM_COLS+c] = cnt_r[r*NUM_COLS+c] + CntW'(1);
        end else begin
          cnt_inc[r*NUM_COLS+c] = cnt_r[r*NUM_COLS+c];
        end
      end
    end

    // Decide pressed and event maps from the updated counts
    for (int k = 0; k < NumKeys; k++) begin
      pressed[k] = (cnt_inc[k] >= threshold_r);
      events[k]  = (!prev_r[k] && pressed[k]) || (held_r[k] >= repeat_r);
    end

    for (int k = 0; k < NumKeys; k++) begin
      if (!close) begin
        cnt_nxt[k]  = cnt_inc[k];
        held_nxt[k] = held_r[k];
      end else begin
        cnt_nxt[k] = '0;
        if (events != '0 || !pressed[k]) begin
          held_nxt[k] = '0;
        end else if (held_r[k] != kpsd_pkg::HeldMax) begin
          held_nxt[k] = held_r[k] + HeldW'(1);
        end else begin
          held_nxt[k] = held_r[k];
        end
      end
    end
    prev_nxt = close ? pressed : prev_r;

    // Form the result transaction
    pressed_ext     = {{MW{1'b0}}, (close ? pressed : {NumKeys{1'b0}})};
    events_ext      = {{MW{1'b0}}, (close ? events : {NumKeys{1'b0}})};
    col_ext         = {{kpsd_pkg::ColW{1'b0}}, col_nxt};
    res.col_drive   = col_ext[kpsd_pkg::ColW-1:0];
    res.window_done = close;
    res.key_state   = pressed_ext[MW-1:0];
    res.key_events  = events_ext[MW-1:0];
  end

  // Update scan state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      round_r <= '0;
      prev_r  <= '0;
      for (int k = 0; k < NumKeys; k++) begin
        cnt_r[k]  <= '0;
        held_r[k] <= '0;
      end
    end else if (push) begin
      col_r   <= col_nxt;
      round_r <= round_nxt;
      prev_r  <= prev_nxt;
      for (int k = 0; k < NumKeys; k++) begin
        cnt_r[k]  <= cnt_nxt[k];
        held_r[k] <= held_nxt[k];
      end
    end
  end

  // Hold results in a head register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_vld_r) begin
          head_vld_r <= 1'b1;
          skid_vld_r <= push;
        end else begin
          head_vld_r <= push;
        end
      end else if (push) begin
        if (head_vld_r) begin
          skid_vld_r <= 1'b1;
        end else begin
          head_vld_r <= 1'b1;
        end
      end
    end
  end

  // Move payloads through the buffer
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_vld_r) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= res;
        end
      end else if (push) begin
        head_r <= res;
      end
    end else if (push) begin
      if (head_vld_r) begin
        skid_r <= res;
      end else begin
        head_r <= res;
      end
    end
  end

  assign out_valid       = head_vld_r;
  assign out_col_drive   = head_r.col_drive;
  assign out_window_done = head_r.window_done;
  assign out_key_state   = head_r.key_state;
  assign out_key_events  = head_r.key_events;

endmodule

`default_nettype wire

[tb/tb_keypad_scan_debounce_repeat.sv]
// Self-checking testbench for keypad_scan_debounce_repeat: drives row samples under several
// register settings and checks every scan report against an internal keypad model.
// Depends on kpsd_pkg and the keypad_scan_debounce_repeat RTL.
module tb_keypad_scan_debounce_repeat;
  import kpsd_pkg::*;

  localparam int NumKeys    = NumRowsDef * NumColsDef;
  localparam int CycleLimit = 400000;
  localparam int MaxShown   = 10;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic [RowW-1:0]     in_row_bits = '0;
  logic                out_stall   = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_stall;
  logic                out_valid;
  logic [ColW-1:0]     out_col_drive;
  logic                out_window_done;
  logic [MapW-1:0]     out_key_state;
  logic [MapW-1:0]     out_key_events;
  logic                cfg_ready;

  keypad_scan_debounce_repeat DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row_bits    (in_row_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_col_drive  (out_col_drive),
    .out_window_done(out_window_done),
    .out_key_state  (out_key_state),
    .out_key_events (out_key_events),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Keypad model state and its copy of the registers
  logic [ColW-1:0]  scan_col;
  logic [CntW-1:0]  round_cnt;
  logic [CntW-1:0]  hit_cnt [NumKeys];
  logic [MapW-1:0]  pressed_map;
  logic [HeldW-1:0] held_cnt [NumKeys];
  logic [CntW-1:0]  cfg_rounds;
  logic [CntW-1:0]  cfg_thresh;
  logic [HeldW-1:0] cfg_repeat;

  res_t report_q[$];
  res_t want;
  bit   gaps_on = 1'b1;
  bit   last_window;
  int   errors;
  int   cycles;
  int   n_samples;
  int   n_windows;
  int   n_events;
  int   n_settings;

  // Toggle the clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("keypad_scan_debounce_repeat regression: fail");
      $finish;
    end
  end

  // Stall the report channel at random
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 11);
  end

  // Compare each accepted report with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("unexpected report: col %0d done %0b state %h events %h",
                   out_col_drive, out_window_done, out_key_state, out_key_events);
      end else begin
        want = report_q.pop_front();
        if (out_col_drive !== want.col_drive || out_window_done !== want.window_done ||
            out_key_state !== want.key_state || out_key_events !== want.key_events) begin
          errors++;
          if (errors <= MaxShown)
            $display("report mismatch (exp/act): col %0d/%0d done %0b/%0b state %h/%h events %h/%h",
                     want.col_drive, out_col_drive, want.window_done, out_window_done,
                     want.key_state, out_key_state, want.key_events, out_key_events);
        end
      end
    end
  end

  // Load the reset state into the model
  task automatic model_reset();
    int k;
    scan_col    = '0;
    round_cnt   = '0;
    pressed_map = '0;
    cfg_rounds  = RoundsReset;
    cfg_thresh  = ThresholdReset;
    cfg_repeat  = RepeatReset;
    for (k = 0; k < NumKeys; k++) begin
      hit_cnt[k]  = '0;
      held_cnt[k] = '0;
    end
  endtask

  // Advance the model by one row sample and return the scan report it causes
  function automatic res_t scan_report(input logic [RowW-1:0] rows);
    res_t rpt;
    int   k;
    int   r;
    logic hit;
    rpt = '0;
    for (r = 0; r < NumRowsDef; r++) begin
      if (rows[r]) begin
        k = r * NumColsDef + scan_col;
        if (hit_cnt[k] != CntMax) hit_cnt[k]++;
      end
    end
    scan_col = scan_col + 1'b1;
    if (scan_col == '0) begin
      round_cnt = round_cnt + 1'b1;
      // a zero round setting closes every round; wrap closes as well
      if (round_cnt >= cfg_rounds || round_cnt == '0) begin
        round_cnt = '0;
        rpt.window_done = 1'b1;
        for (k = 0; k < NumKeys; k++) begin
          hit = hit_cnt[k] >= cfg_thresh;
          if ((!pressed_map[k] && hit) || held_cnt[k] >= cfg_repeat) begin
            held_cnt[k] = '0;
            rpt.key_events[k] = 1'b1;
          end
          if (hit) begin
            rpt.key_state[k] = 1'b1;
            if (held_cnt[k] != HeldMax) held_cnt[k]++;
          end else begin
            held_cnt[k] = '0;
          end
          hit_cnt[k] = '0;
        end
        // any event restarts every repeat count
        if (rpt.key_events != '0) begin
          for (k = 0; k < NumKeys; k++) held_cnt[k] = '0;
        end
        pressed_map = rpt.key_state;
      end
    end
    rpt.col_drive = scan_col;
    return rpt;
  endfunction

  // Send one row sample transaction and queue its predicted report
  task automatic send_sample(input logic [RowW-1:0] rows);
    res_t rpt;
    while (gaps_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_row_bits <= rows;
    do @(posedge clk); while (in_stall);
    rpt = scan_report(rows);
    report_q.push_back(rpt);
    last_window = rpt.window_done;
    n_samples++;
    if (rpt.window_done) n_windows++;
    n_events += $countones(rpt.key_events);
  endtask

  // Hold off the sender until every predicted report has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register; cfg_valid stays high for a following write
  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] data);
    if (!cfg_valid) cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROUNDS:    cfg_rounds = data;
      CFG_THRESHOLD: cfg_thresh = data;
      CFG_REPEAT:    cfg_repeat = data[HeldW-1:0];
      default: ;
    endcase
  endtask

  // Drain, then load all three registers
  task automatic configure(input logic [CntW-1:0] rounds, input logic [CntW-1:0] thresh,
                           input logic [CfgDataW-1:0] rep_data);
    wait_idle();
    write_reg(CFG_ROUNDS, rounds);
    write_reg(CFG_THRESHOLD, thresh);
    write_reg(CFG_REPEAT, rep_data);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // Drive held-key patterns with bounce noise and occasional raw samples
  task automatic run_held_keys(input int count);
    logic [MapW-1:0] held_mask;
    logic [RowW-1:0] rows;
    int              i;
    int              r;
    held_mask = MapW'($urandom);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        rows = RowW'($urandom);
      end else begin
        for (r = 0; r < NumRowsDef; r++)
          rows[r] = held_mask[r * NumColsDef + scan_col] ^ ($urandom_range(99) < 6);
      end
      send_sample(rows);
      // change the held keys now and then at a window boundary
      if (last_window && $urandom_range(99) < 30) begin
        if ($urandom_range(3) == 0) held_mask = MapW'($urandom);
        else held_mask = held_mask ^ (16'h1 << $urandom_range(15));
      end
      if ($urandom_range(999) < 5) wait_idle();
    end
  endtask

  // Run part of a default window, then shrink the window to one round so the current round closes it
  task automatic test_reset_defaults();
    send_sample(4'hF);
    send_sample(4'h0);
    wait_idle();
    write_reg(CFG_ROUNDS, 10'd1);
    cfg_valid <= 1'b0;
    send_sample(4'hF);
    send_sample(4'hF);
  endtask

  // Walk the press, repeat, zero-setting and unused-register cases
  task automatic test_directed();
    int i;
    configure(10'd1, 10'd1, 10'd1);
    for (i = 0; i < 8; i++) send_sample(4'hF);
    wait_idle();
    write_reg(CFG_UNUSED, 10'h3FF);
    cfg_valid <= 1'b0;
    configure(10'd0, 10'd0, 10'd0);
    for (i = 0; i < 4; i++) send_sample(4'h0);
    configure(10'd1, 10'd1023, 10'd1);
    for (i = 0; i < 4; i++) send_sample(4'hF);
    configure(10'd1, 10'd1, 10'h3FF);
    send_sample(4'h5);
    send_sample(4'hA);
    send_sample(4'h3);
    send_sample(4'hC);
  endtask

  // Open the largest window with every key down, then shrink it so the next round closes it
  task automatic test_max_window();
    int i;
    configure(10'd1023, 10'd1023, 10'd15);
    for (i = 0; i < 10 * NumColsDef; i++) send_sample(4'hF);
    configure(10'd1, 10'd8, 10'd15);
    for (i = 0; i < NumColsDef; i++) send_sample(4'hF);
  endtask

  // Random settings with small windows and held-key traffic
  task automatic test_random_phases();
    logic [CntW-1:0] rounds;
    int              span;
    int              p;
    for (p = 0; p < 10; p++) begin
      rounds = CntW'($urandom_range(6));
      span   = (rounds == 0) ? 1 : rounds;
      configure(rounds, CntW'($urandom_range(span + 1)),
                {6'($urandom_range(63)), 4'($urandom_range(15))});
      run_held_keys(120);
    end
  endtask

  // Back-to-back transactions with no gaps on either side
  task automatic test_no_gaps();
    configure(10'd3, 10'd2, 10'd2);
    gaps_on = 1'b0;
    run_held_keys(300);
    gaps_on = 1'b1;
  endtask

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_max_window();
    test_random_phases();
    test_no_gaps();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("covered %0d row samples over %0d register settings", n_samples, n_settings);
    $display("saw %0d debounce windows and %0d key events, %0d mismatches",
             n_windows, n_events, errors);
    if (errors == 0) begin
      $display("keypad_scan_debounce_repeat regression: pass");
    end else begin
      $display("keypad_scan_debounce_repeat regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/kpsd_pkg.sv
rtl/keypad_scan_debounce_repeat.sv
tb/tb_keypad_scan_debounce_repeat.sv
